### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and masked during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BLP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types and constants of the buffer pool free list.
// ----------------------------------------------------------------------------
package blp_pkg;

	localparam int ID_W           = 6;
	localparam int OUT_CNT_W      = 16;
	localparam int NUM_BUFFERS_DEF = 64;
	localparam int COUNT_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		FUNC_PIN   = 2'd0,
		FUNC_UNPIN = 2'd1,
		FUNC_GET   = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_UNPINNED  = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [ID_W-1:0]   buffer_id;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [ID_W-1:0]      result_id;
		logic [OUT_CNT_W-1:0] pin_count;
	} rsp_t;

endpackage

### hdl/blp_ram.sv
// ----------------------------------------------------------------------------
// blp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module blp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/blp_init.sv
// ----------------------------------------------------------------------------
// blp_init
// Post-reset sweep: walks every list entry and produces its initial links,
// the ring 0..N-1 with the sentinel inserted after buffer 0.
// ----------------------------------------------------------------------------
module blp_init #(
	parameter int NUM_BUFFERS = 64,
	localparam int LW = $clog2(NUM_BUFFERS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [LW-1:0] idx,
	output logic [LW-1:0] next_val,
	output logic [LW-1:0] prev_val
);

	localparam logic [LW-1:0] SENT = LW'(NUM_BUFFERS);
	localparam logic [LW-1:0] LAST = LW'(NUM_BUFFERS - 1);
	localparam logic [LW-1:0] ONE  = LW'(1);

	logic          busy_q;
	logic [LW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == SENT) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + ONE;
			end
		end
	end

	always_comb begin
		priority if (idx_q == SENT) begin
			next_val = ONE;
		end else if (idx_q == '0) begin
			next_val = SENT;
		end else if (idx_q == LAST) begin
			next_val = '0;
		end else begin
			next_val = idx_q + ONE;
		end

		priority if (idx_q == SENT) begin
			prev_val = '0;
		end else if (idx_q == ONE) begin
			prev_val = SENT;
		end else if (idx_q == '0) begin
			prev_val = LAST;
		end else begin
			prev_val = idx_q - ONE;
		end
	end

	assign busy = busy_q;
	assign idx  = idx_q;

endmodule

### hdl/buffer_pool_lru_freelist.sv
// ----------------------------------------------------------------------------
// buffer_pool_lru_freelist
// Pin / unpin / get-free on a doubly linked LRU free list of buffers.
// ----------------------------------------------------------------------------
// Free buffers sit on a circular doubly linked list through a sentinel head;
// next links, prev links and the {free, pin count} word of each buffer live in
// three RAMs with registered reads. After reset a clearing pass writes the
// NUM_BUFFERS+1 list entries, and requests stall until it ends. Each request
// is then read, updated and written back by a sequencer: pin, an unpin that
// does not append, out-of-range ids, the unused code and get-free on an empty
// list pass through LOOK, EVAL and DONE and return to IDLE for the next
// request. Get-free that takes a buffer and an unpin that appends to the tail
// take a longer path: get-free runs LOOK and EVAL again for a second link
// read (list head, then the head entry's links) through the single read port
// of the link RAMs, the append runs APP_A and APP_B for a second write to
// each link RAM through its single write port. A held output keeps the
// sequencer in DONE. One request is in flight at a time; the next is accepted
// while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module buffer_pool_lru_freelist #(
	parameter int NUM_BUFFERS = blp_pkg::NUM_BUFFERS_DEF,
	parameter int COUNT_BITS  = blp_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  blp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output blp_pkg::rsp_t rsp
);

	import blp_pkg::*;

	localparam int LW = $clog2(NUM_BUFFERS + 1);
	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int SW = COUNT_BITS + 1;
	localparam logic [LW-1:0]         SENT    = LW'(NUM_BUFFERS);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_LOOK  = 7'b0000100,
		ST_EVAL  = 7'b0001000,
		ST_APP_A = 7'b0010000,
		ST_APP_B = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic          init_busy;
	logic [LW-1:0] init_idx, init_next, init_prev;

	logic          next_we, prev_we, st_we;
	logic [LW-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
	logic [LW-1:0] prev_waddr, prev_wdata, prev_raddr, prev_rdata;
	logic [IW-1:0] st_waddr, st_raddr;
	logic [SW-1:0] st_wdata, st_rdata;

	func_t           func_q;
	logic [ID_W-1:0] id_q;
	logic            in_range_q;
	logic [LW-1:0]   cur_q, cur_d;
	logic [LW-1:0]   tail_q, tail_d;
	logic            hop_q, hop_d;
	rsp_t            res_q, res_d;
	rsp_t            rsp_q;
	logic            rsp_valid_q;
	logic            rsp_load;

	logic [COUNT_BITS-1:0] cnt, cnt_inc, cnt_dec;
	logic                  fr;

	blp_init #(.NUM_BUFFERS(NUM_BUFFERS)) u_init (
		.clk      (clk),
		.arst_n   (arst_n),
		.busy     (init_busy),
		.idx      (init_idx),
		.next_val (init_next),
		.prev_val (init_prev)
	);

	blp_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS + 1)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (next_raddr),
		.rdata (next_rdata)
	);

	blp_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS + 1)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (prev_raddr),
		.rdata (prev_rdata)
	);

	blp_ram #(.WIDTH(SW), .DEPTH(NUM_BUFFERS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign cnt     = st_rdata[COUNT_BITS-1:0];
	assign fr      = st_rdata[COUNT_BITS];
	assign cnt_inc = cnt + CNT_ONE;
	assign cnt_dec = cnt - CNT_ONE;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		hop_d      = hop_q;
		tail_d     = tail_q;
		res_d      = res_q;
		next_we    = 1'b0;
		next_waddr = cur_q;
		next_wdata = SENT;
		prev_we    = 1'b0;
		prev_waddr = cur_q;
		prev_wdata = SENT;
		st_we      = 1'b0;
		st_waddr   = IW'(cur_q);
		st_wdata   = '0;
		next_raddr = cur_q;
		prev_raddr = cur_q;
		st_raddr   = IW'(cur_q);

		unique case (state_q)
			ST_INIT: begin
				next_we    = 1'b1;
				next_waddr = init_idx;
				next_wdata = init_next;
				prev_we    = 1'b1;
				prev_waddr = init_idx;
				prev_wdata = init_prev;
				st_we      = (init_idx != SENT);
				st_waddr   = IW'(init_idx);
				st_wdata   = {1'b1, {COUNT_BITS{1'b0}}};
				if (!init_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cur_d   = LW'(req.buffer_id);
					hop_d   = 1'b0;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// first pass of get-free reads the list head
				if (func_q == FUNC_GET && !hop_q) begin
					next_raddr = SENT;
				end
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				// tail lookup for a possible append
				prev_raddr = SENT;
				state_d    = ST_DONE;
				unique case (func_q)
					FUNC_GET: begin
						if (!hop_q) begin
							if (32'(next_rdata) >= NUM_BUFFERS) begin
								res_d = '{STAT_EMPTY, '0, '0};
							end else begin
								cur_d   = next_rdata;
								hop_d   = 1'b1;
								state_d = ST_LOOK;
							end
						end else begin
							// unlink head: prev[n] = p, next[p] = n
							prev_we    = 1'b1;
							prev_waddr = next_rdata;
							prev_wdata = prev_rdata;
							next_we    = 1'b1;
							next_waddr = prev_rdata;
							next_wdata = next_rdata;
							st_we      = 1'b1;
							st_wdata   = {1'b0, cnt};
							res_d      = '{STAT_OK, ID_W'(cur_q), OUT_CNT_W'(cnt)};
						end
					end
					FUNC_PIN: begin
						if (!in_range_q) begin
							res_d = '{STAT_OK, id_q, '0};
						end else if (cnt == CNT_MAX) begin
							res_d = '{STAT_OVERFLOW, id_q, OUT_CNT_W'(cnt)};
						end else begin
							if (cnt == '0 && fr) begin
								prev_we    = 1'b1;
								prev_waddr = next_rdata;
								prev_wdata = prev_rdata;
								next_we    = 1'b1;
								next_waddr = prev_rdata;
								next_wdata = next_rdata;
							end
							st_we    = 1'b1;
							st_wdata = {fr && (cnt != '0), cnt_inc};
							res_d    = '{STAT_OK, id_q, OUT_CNT_W'(cnt_inc)};
						end
					end
					FUNC_UNPIN: begin
						if (!in_range_q) begin
							res_d = '{STAT_OK, id_q, '0};
						end else if (cnt == '0) begin
							res_d = '{STAT_UNPINNED, id_q, '0};
						end else begin
							st_we    = 1'b1;
							st_wdata = {fr || (cnt_dec == '0), cnt_dec};
							res_d    = '{STAT_OK, id_q, OUT_CNT_W'(cnt_dec)};
							if (cnt_dec == '0 && !fr) begin
								state_d = ST_APP_A;
							end
						end
					end
					FUNC_NONE: begin
						res_d = '{STAT_OK, id_q, in_range_q ? OUT_CNT_W'(cnt) : '0};
					end
				endcase
			end
			ST_APP_A: begin
				// prev[b] = tail, next[b] = sentinel
				prev_we    = 1'b1;
				prev_wdata = prev_rdata;
				next_we    = 1'b1;
				next_wdata = SENT;
				tail_d     = prev_rdata;
				state_d    = ST_APP_B;
			end
			ST_APP_B: begin
				// prev[sentinel] = b, next[tail] = b
				prev_we    = 1'b1;
				prev_waddr = SENT;
				prev_wdata = cur_q;
				next_we    = 1'b1;
				next_waddr = tail_q;
				next_wdata = cur_q;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			hop_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hop_q   <= hop_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			func_q     <= req.func;
			id_q       <= req.buffer_id;
			in_range_q <= (32'(req.buffer_id) < NUM_BUFFERS);
		end
		cur_q  <= cur_d;
		tail_q <= tail_d;
		res_q  <= res_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	`include "assert_macros.svh"

	`BLP_ASSERT(a_no_req_in_init, init_busy, req_stall, "request taken during clearing pass")
	`BLP_ASSERT_NEXT(a_done_holds, state_q == ST_DONE && rsp_valid && rsp_stall, state_q == ST_DONE, "result dropped while output full")
	`BLP_ASSERT(a_link_wr_state, (next_we || prev_we) && state_q != ST_INIT, state_q == ST_EVAL || state_q == ST_APP_A || state_q == ST_APP_B, "link write outside update states")

endmodule
